// ===== rtl/windowed_register_file_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the windowed register file unit
// ---------------------------------------------------------------------------
`ifndef WINDOWED_REGISTER_FILE_UNIT_ASSERT_SVH
`define WINDOWED_REGISTER_FILE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define WRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define WRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wrf_pkg
// Shared constants, operation codes and types of the windowed register file.
// ---------------------------------------------------------------------------
package wrf_pkg;

   // Architectural layout
   localparam int WIN_SIZE        = 16;
   localparam int NUM_GLOBALS     = 8;
   localparam int DEF_NUM_WINDOWS = 32;

   // Field widths
   localparam int FUNC_W   = 2;
   localparam int REG_IDX_W = 5;
   localparam int GLB_IDX_W = 3;
   localparam int DATA_W   = 32;
   localparam int CWIN_W   = 5;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SAVE    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd3;

   // Item held between the memory read and the output register
   typedef struct packed {
      logic              is_read;
      logic              is_global;
      logic              trap;
      logic [CWIN_W-1:0] window;
      logic [DATA_W-1:0] glb_data;
   } stage_type;

endpackage
`default_nettype wire

// ===== rtl/windowed_register_file_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request beat goes through stage 1 and the output register.
// Throughput: one beat per cycle while rsp_stall is low (one store read port).
// Reset: after reset the store is swept to zero, one entry a cycle, over all
//   NUM_WINDOWS*16 entries (512 by default); requests are stalled meanwhile,
//   CSR writes are taken. Globals, window pointer and mask reset to zero.
// ---------------------------------------------------------------------------
// windowed_register_file_unit
// Windowed register file: 8 globals in flops, overlapping windows of 16
// registers in a synchronous memory, save/restore with invalid-window trap.
// ---------------------------------------------------------------------------
`include "windowed_register_file_unit_assert.svh"

module windowed_register_file_unit
   import wrf_pkg::*;
#(
   parameter int NUM_WINDOWS = DEF_NUM_WINDOWS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [REG_IDX_W-1:0] req_reg_index,
   input  wire logic [DATA_W-1:0]    req_write_data,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DATA_W-1:0]         rsp_read_data,
   output logic                      rsp_window_trap,
   output logic [CWIN_W-1:0]         rsp_current_window,
   // CSR port
   input  wire logic                 csr_wr_en,
   input  wire logic [DATA_W-1:0]    csr_wr_data
);

   localparam int DEPTH  = NUM_WINDOWS * WIN_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int WP_W   = $clog2(NUM_WINDOWS);

   // state
   logic [DATA_W-1:0] store [DEPTH];
   logic [DATA_W-1:0] store_rdata_ff;
   logic [DATA_W-1:0] glb_ff [NUM_GLOBALS];
   logic [WP_W-1:0]   wp_ff, wp_in;
   logic [DATA_W-1:0] mask_ff;
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_idx_ff;
   logic              s1_valid_ff;
   stage_type         s1_ff, s1_in;
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_trap_ff;
   logic [CWIN_W-1:0] out_win_ff;

   logic              req_acc, s1_adv;
   logic              is_global;
   logic [REG_IDX_W-1:0] win_off;
   logic [SUM_W-1:0]  addr_sum;
   logic [ADDR_W-1:0] addr;
   logic [WP_W-1:0]   wp_prev, wp_next, wp_target;
   logic              is_win_op, trap;
   logic              st_we;
   logic [ADDR_W-1:0] st_waddr;
   logic [DATA_W-1:0] st_wdata;

   // handshake
   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_adv);
   assign req_acc   = req_valid && !req_stall;

   // address of a windowed register, wrapped once past the store end
   assign is_global = (req_reg_index < REG_IDX_W'(NUM_GLOBALS));
   assign win_off   = req_reg_index - REG_IDX_W'(NUM_GLOBALS);
   assign addr_sum  = SUM_W'({wp_ff, 4'b0000}) + SUM_W'(win_off);
   always_comb begin
      if (addr_sum >= SUM_W'(DEPTH)) begin
         addr = ADDR_W'(addr_sum - SUM_W'(DEPTH));
      end else begin
         addr = addr_sum[ADDR_W-1:0];
      end
   end

   // window moves and trap check
   assign wp_prev   = (wp_ff == '0) ? WP_W'(NUM_WINDOWS - 1) : wp_ff - 1'b1;
   assign wp_next   = (wp_ff == WP_W'(NUM_WINDOWS - 1)) ? '0 : wp_ff + 1'b1;
   assign wp_target = (req_func == FUNC_SAVE) ? wp_prev : wp_next;
   assign is_win_op = (req_func == FUNC_SAVE) || (req_func == FUNC_RESTORE);
   assign trap      = is_win_op && mask_ff[CWIN_W'(wp_target)];

   always_comb begin
      wp_in = wp_ff;
      if (req_acc && is_win_op && !trap) begin
         wp_in = wp_target;
      end
   end

   always_comb begin
      s1_in.is_read   = (req_func == FUNC_READ);
      s1_in.is_global = is_global;
      s1_in.trap      = trap;
      s1_in.window    = CWIN_W'(wp_in);
      s1_in.glb_data  = glb_ff[req_reg_index[GLB_IDX_W-1:0]];
   end

   // store write port: clearing sweep or register write
   always_comb begin
      if (clearing_ff) begin
         st_we    = 1'b1;
         st_waddr = clr_idx_ff;
         st_wdata = '0;
      end else begin
         st_we    = req_acc && (req_func == FUNC_WRITE) && !is_global;
         st_waddr = addr;
         st_wdata = req_write_data;
      end
   end

   // windowed store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (st_we) begin
         store[st_waddr] <= st_wdata;
      end
      if (req_acc && (req_func == FUNC_READ) && !is_global) begin
         store_rdata_ff <= store[addr];
      end
   end

   // globals, pointer, mask and clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GLOBALS; i++) begin
            glb_ff[i] <= '0;
         end
         wp_ff       <= '0;
         mask_ff     <= '0;
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         if (req_acc && (req_func == FUNC_WRITE) && is_global) begin
            glb_ff[req_reg_index[GLB_IDX_W-1:0]] <= req_write_data;
         end
         wp_ff <= wp_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == ADDR_W'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   // stage 1: waits for the store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (!s1_ff.is_read) begin
            out_data_ff <= '0;
         end else if (s1_ff.is_global) begin
            out_data_ff <= s1_ff.glb_data;
         end else begin
            out_data_ff <= store_rdata_ff;
         end
         out_trap_ff <= s1_ff.trap;
         out_win_ff  <= s1_ff.window;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = out_data_ff;
   assign rsp_window_trap    = out_trap_ff;
   assign rsp_current_window = out_win_ff;

   // checks
   `WRF_ASSERT_NEXT(a_trap_keeps_window, req_acc && trap, wp_ff == $past(wp_ff),
      "window pointer moved on a trap")
   `WRF_ASSERT_NOW(a_window_in_range, 1'b1, wp_ff <= WP_W'(NUM_WINDOWS - 1),
      "window pointer out of range")
   `WRF_ASSERT_NOW(a_trap_has_no_data, rsp_valid && rsp_window_trap,
      rsp_read_data == '0, "trap beat carries read data")
   `WRF_ASSERT_NEXT(a_sweep_ends, clearing_ff && (clr_idx_ff == ADDR_W'(DEPTH - 1)),
      !clearing_ff, "clearing sweep did not finish")
   `WRF_ASSERT_NOW(a_no_item_in_sweep, clearing_ff, !s1_valid_ff && !out_valid_ff,
      "item in flight during clearing sweep")

endmodule
`default_nettype wire

// ===== sim/windowed_register_file_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// windowed_register_file_unit_test
// Self-checking bench for the windowed register file. It keeps its own copy
// of the globals, the window store, the window pointer and the invalid-window
// mask, and predicts every response beat. The run steps through several mask
// settings, with random gaps on both channels and one long response hold-off.
// ---------------------------------------------------------------------------
module windowed_register_file_unit_test;
   import wrf_pkg::*;

   localparam int NWIN        = DEF_NUM_WINDOWS;
   localparam int STORE_DEPTH = NWIN * WIN_SIZE;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 6;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [REG_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    data;
   } access_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              trap;
      logic [CWIN_W-1:0] window;
   } access_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func       = '0;
   logic [REG_IDX_W-1:0] req_reg_index  = '0;
   logic [DATA_W-1:0]    req_write_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [DATA_W-1:0]    rsp_read_data;
   logic                 rsp_window_trap;
   logic [CWIN_W-1:0]    rsp_current_window;
   logic                 csr_wr_en      = 1'b0;
   logic [DATA_W-1:0]    csr_wr_data    = '0;

   windowed_register_file_unit #(
      .NUM_WINDOWS(NWIN)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_reg_index      (req_reg_index),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_window_trap    (rsp_window_trap),
      .rsp_current_window (rsp_current_window),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Mirror of the architectural state
   logic [DATA_W-1:0] glob_file [NUM_GLOBALS];
   logic [DATA_W-1:0] window_store [STORE_DEPTH];
   logic [CWIN_W-1:0] cur_win;
   logic [NWIN-1:0]   bad_win_mask;

   access_req_type request_q [$];
   access_rsp_type predicted_rsp_q [$];

   int unsigned items_queued   = 0;
   int unsigned beats_accepted = 0;
   int unsigned rsp_matched    = 0;
   int unsigned mismatches     = 0;
   int unsigned cycle_count    = 0;
   int unsigned n_reads = 0, n_writes = 0, n_moves = 0, n_traps = 0, n_masks = 0;
   logic [NWIN-1:0] wins_visited = '0;
   logic req_taken = 1'b0;
   logic calm_stretch;

   assign calm_stretch = (beats_accepted >= 900) && (beats_accepted < 1200);

   initial begin
      forever #1 clock = ~clock;
   end

   // Physical slot of a windowed register, wrapped around the store
   function automatic int unsigned store_slot(logic [REG_IDX_W-1:0] idx);
      return (int'(cur_win) * WIN_SIZE + int'(idx) - NUM_GLOBALS) % STORE_DEPTH;
   endfunction

   // Applies one request to the mirror and returns the response it should give
   function automatic access_rsp_type register_file_step(access_req_type r);
      access_rsp_type res;
      logic [CWIN_W-1:0] nxt;
      res = '0;
      case (r.func)
         FUNC_READ: begin
            n_reads++;
            if (r.idx < NUM_GLOBALS) res.read_data = glob_file[r.idx[GLB_IDX_W-1:0]];
            else res.read_data = window_store[store_slot(r.idx)];
         end
         FUNC_WRITE: begin
            n_writes++;
            if (r.idx < NUM_GLOBALS) glob_file[r.idx[GLB_IDX_W-1:0]] = r.data;
            else window_store[store_slot(r.idx)] = r.data;
         end
         default: begin
            if (r.func == FUNC_SAVE) nxt = (cur_win == 0) ? CWIN_W'(NWIN - 1) : cur_win - 1'b1;
            else nxt = CWIN_W'((int'(cur_win) + 1) % NWIN);
            n_moves++;
            if (bad_win_mask[nxt]) begin
               res.trap = 1'b1;
               n_traps++;
            end else begin
               cur_win = nxt;
            end
         end
      endcase
      res.window = cur_win;
      wins_visited[cur_win] = 1'b1;
      return res;
   endfunction

   // Request driver: next beat is offered once the current one has gone
   always @(negedge clock) begin : drive_requests
      logic idle_now;
      access_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         idle_now = !calm_stretch && ($urandom_range(99) < 14);
         if (!idle_now && request_q.size() != 0) begin
            nxt = request_q.pop_front();
            req_valid      <= 1'b1;
            req_func       <= nxt.func;
            req_reg_index  <= nxt.idx;
            req_write_data <= nxt.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls plus one long hold-off to back the block up
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   always @(negedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && beats_accepted >= 400) begin
         hold_done = 1'b1;
         hold_left = 80;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm_stretch && ($urandom_range(99) < 14);
      end
   end

   // Port monitor: mask writes, accepted requests and response checks
   always @(posedge clock) begin : watch_ports
      access_rsp_type want;
      access_req_type acc;
      req_taken = !reset && req_valid && !req_stall;
      if (csr_wr_en) begin
         bad_win_mask = csr_wr_data[NWIN-1:0];
         n_masks++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: read_data %h trap %b window %0d",
                        rsp_read_data, rsp_window_trap, rsp_current_window);
         end else begin
            want = predicted_rsp_q.pop_front();
            rsp_matched++;
            if (rsp_read_data !== want.read_data || rsp_window_trap !== want.trap
                || rsp_current_window !== want.window) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d mismatch: read_data %h/%h trap %b/%b window %0d/%0d",
                           rsp_matched, want.read_data, rsp_read_data, want.trap,
                           rsp_window_trap, want.window, rsp_current_window,
                           " (expected/actual)");
            end
         end
      end
      if (req_taken) begin
         acc.func = req_func;
         acc.idx  = req_reg_index;
         acc.data = req_write_data;
         predicted_rsp_q.push_back(register_file_step(acc));
         beats_accepted++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout: %0d of %0d responses after %0d cycles",
                  rsp_matched, items_queued, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_item(logic [FUNC_W-1:0] func, logic [REG_IDX_W-1:0] idx,
                             logic [DATA_W-1:0] data);
      access_req_type r;
      r.func = func;
      r.idx  = idx;
      r.data = data;
      request_q.push_back(r);
      items_queued++;
   endtask

   function automatic logic [DATA_W-1:0] rand_data();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Random traffic: mostly call/return sequences around loose accesses
   task automatic queue_random(int count);
      int pick, j;
      logic [FUNC_W-1:0] f;
      while (count > 0) begin
         if ($urandom_range(3) == 0) begin
            // caller fills its outs, callee sees them as ins, then returns
            for (j = 0; j < 3; j++) queue_item(FUNC_WRITE, 5'($urandom_range(8, 15)), rand_data());
            queue_item(FUNC_SAVE, 5'($urandom_range(31)), rand_data());
            queue_item(FUNC_READ, 5'($urandom_range(24, 31)), rand_data());
            queue_item(FUNC_WRITE, 5'($urandom_range(16, 31)), rand_data());
            queue_item(FUNC_RESTORE, 5'($urandom_range(31)), rand_data());
            queue_item(FUNC_READ, 5'($urandom_range(8, 15)), rand_data());
            count -= 8;
         end else begin
            pick = $urandom_range(99);
            if (pick < 38) f = FUNC_READ;
            else if (pick < 76) f = FUNC_WRITE;
            else if (pick < 88) f = FUNC_SAVE;
            else f = FUNC_RESTORE;
            queue_item(f, 5'($urandom_range(31)), rand_data());
            count--;
         end
      end
   endtask

   // Let everything drain, then change the mask while the block is idle
   task automatic write_mask_when_idle(logic [DATA_W-1:0] value);
      while (rsp_matched != items_queued) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus and end of run
   initial begin
      foreach (glob_file[i]) glob_file[i] = '0;
      foreach (window_store[i]) window_store[i] = '0;
      cur_win      = '0;
      bad_win_mask = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // All windows valid: register zero, wrap of pointer and store, overlap
      write_mask_when_idle(32'h0000_0000);
      queue_item(FUNC_READ,    5'd0,  32'h0);
      queue_item(FUNC_WRITE,   5'd0,  32'hFFFF_FFFF);
      queue_item(FUNC_READ,    5'd0,  32'h0);
      queue_item(FUNC_WRITE,   5'd31, 32'hFFFF_FFFF);
      queue_item(FUNC_WRITE,   5'd8,  32'hA5A5_A5A5);
      queue_item(FUNC_WRITE,   5'd7,  32'h0000_0001);
      queue_item(FUNC_SAVE,    5'd0,  32'h0);
      queue_item(FUNC_READ,    5'd24, 32'h0);
      queue_item(FUNC_READ,    5'd31, 32'h0);
      queue_item(FUNC_WRITE,   5'd31, 32'h1234_5678);
      queue_item(FUNC_RESTORE, 5'd0,  32'h0);
      queue_item(FUNC_READ,    5'd15, 32'h0);
      queue_item(FUNC_RESTORE, 5'd0,  32'h0);
      queue_item(FUNC_READ,    5'd15, 32'h0);
      queue_item(FUNC_READ,    5'd7,  32'h0);
      queue_random(500);

      // Every window invalid: each move traps, accesses go on
      write_mask_when_idle(32'hFFFF_FFFF);
      queue_item(FUNC_SAVE,    5'd0,  32'h0);
      queue_item(FUNC_RESTORE, 5'd31, 32'hFFFF_FFFF);
      queue_item(FUNC_WRITE,   5'd1,  32'h8000_0000);
      queue_item(FUNC_READ,    5'd1,  32'h0);
      queue_item(FUNC_WRITE,   5'd16, 32'hFFFF_FFFF);
      queue_item(FUNC_READ,    5'd16, 32'h0);
      queue_random(150);

      // Sparse random mask
      write_mask_when_idle($urandom() & $urandom());
      queue_random(600);

      // First and last windows invalid: wrapping moves trap
      write_mask_when_idle(32'h8000_0001);
      queue_random(300);

      write_mask_when_idle(32'h0000_0000);
      queue_random(330);

      while (rsp_matched != items_queued) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (predicted_rsp_q.size() != 0) mismatches += predicted_rsp_q.size();
      $display("%0d beats checked: %0d reads, %0d writes, %0d window moves (%0d trapped)",
               rsp_matched, n_reads, n_writes, n_moves, n_traps);
      $display("%0d mask writes, %0d of %0d windows entered, %0d mismatches",
               n_masks, $countones(wins_visited), NWIN, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
